### rtl/core/mfb_pkg.sv
`timescale 1ns / 1ps
package mfb_pkg;

  // Command codes.
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_PIXEL  = 3'd1;
  localparam logic [2:0] FUNC_LINE   = 3'd2;
  localparam logic [2:0] FUNC_CIRCLE = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Shape being plotted.
  localparam logic [1:0] SHAPE_PIXEL  = 2'd0;
  localparam logic [1:0] SHAPE_LINE   = 2'd1;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic [6:0] radius;
    logic       pixel_on;
    logic [8:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] func_done;
  } out_word_t;

endpackage

### rtl/core/mono_framebuffer_line_circle_engine.sv
`timescale 1ns / 1ps
// Each command works through the store's single port pair: clear zeroes every byte, a read
// fetches one byte, a pixel is one read-modify-write plot, a line is a plot and a step per
// plotted pixel, and a circle is four read-modify-write plots and one step per circle step.
// One command at a time; the next word can be taken in the cycle after the result is registered,
// even while that result waits on the output.
// Reset (synchronous) runs a clearing pass over all STORE_BYTES bytes before the first
// word is accepted.
module mono_framebuffer_line_circle_engine #(
  parameter int COLUMNS     = 84,
  parameter int STORE_BYTES = 504
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfb_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfb_pkg::out_word_t out_data
);
  import mfb_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CLEAR    = 9'b000000100,
    S_PLOT_RD  = 9'b000001000,
    S_PLOT_WR  = 9'b000010000,
    S_LSTEP    = 9'b000100000,
    S_CSTEP    = 9'b001000000,
    S_READ     = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state;

  logic [AW-1:0] clr_cnt;
  logic [1:0]    shape;
  logic [1:0]    k;
  logic          pix_on;
  logic [7:0]    cx, cy, xb, yb, xc, yc;
  logic          sx, sy;
  logic signed [12:0] dx, dy, err;
  logic signed [12:0] ccx, ccy;
  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_bit;
  logic          wr_hit, rd_hit;
  logic [2:0]    res_func;
  logic [7:0]    res_data;
  logic          out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  mfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Current plot point: the pixel or line cursor, or one of the circle's four mirrors.
  logic [7:0] pt_x, pt_y;
  always_comb begin
    pt_x = cx;
    pt_y = cy;
    if (shape == SHAPE_CIRCLE) begin
      case (k)
        2'd0: begin pt_x = xc - ccx[7:0]; pt_y = yc + ccy[7:0]; end
        2'd1: begin pt_x = xc + ccx[7:0]; pt_y = yc + ccy[7:0]; end
        2'd2: begin pt_x = xc + ccx[7:0]; pt_y = yc - ccy[7:0]; end
        default: begin pt_x = xc - ccx[7:0]; pt_y = yc - ccy[7:0]; end
      endcase
    end
  end

  // Byte index of the plot point; its range check is registered with the write address.
  logic [15:0] pt_idx;
  assign pt_idx = 16'(pt_y[7:3]) * 16'(COLUMNS) + 16'(pt_x);

  // Bresenham step.
  logic signed [12:0] l_e2, l_err;
  logic [7:0]         l_cx, l_cy;
  logic               l_done;
  always_comb begin
    l_e2   = err <<< 1;
    l_err  = err;
    l_cx   = cx;
    l_cy   = cy;
    l_done = 1'b0;
    if (l_e2 >= dy) begin
      if (cx == xb) begin
        l_done = 1'b1;
      end else begin
        l_err = l_err + dy;
        l_cx  = sx ? cx + 8'd1 : cx - 8'd1;
      end
    end
    if (!l_done && l_e2 <= dx) begin
      if (cy == yb) begin
        l_done = 1'b1;
      end else begin
        l_err = l_err + dx;
        l_cy  = sy ? cy + 8'd1 : cy - 8'd1;
      end
    end
  end

  // Midpoint circle step.
  logic signed [12:0] c_e2, c_err, c_x, c_y;
  always_comb begin
    c_e2  = err;
    c_err = err;
    c_x   = ccx;
    c_y   = ccy;
    if (c_e2 <= ccy) begin
      c_y   = ccy + 13'sd1;
      c_err = c_err + (c_y <<< 1) + 13'sd1;
      if (-ccx == c_y && c_e2 <= ccx) begin
        c_e2 = 13'sd0;
      end
    end
    if (c_e2 > ccx) begin
      c_x   = ccx + 13'sd1;
      c_err = c_err + (c_x <<< 1) + 13'sd1;
    end
  end

  // Store port selection.
  always_comb begin
    ram_raddr = (state == S_IDLE) ? AW'(in_data.read_index) : pt_idx[AW-1:0];
    ram_waddr = wr_addr;
    ram_wdata = pix_on ? (ram_rdata | (8'd1 << wr_bit)) : (ram_rdata & ~(8'd1 << wr_bit));
    ram_we    = (state == S_PLOT_WR) && wr_hit;
    if (state == S_INIT || state == S_CLEAR) begin
      ram_waddr = clr_cnt;
      ram_wdata = 8'd0;
      ram_we    = 1'b1;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Output register, so a waiting result is kept while the next command runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_data  <= '{read_data: res_data, func_done: res_func};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  logic [15:0] in_dx, in_dy;
  assign in_dx = (in_data.x_second >= in_data.x_first) ?
                 16'(in_data.x_second - in_data.x_first) :
                 16'(in_data.x_first - in_data.x_second);
  assign in_dy = (in_data.y_second >= in_data.y_first) ?
                 16'(in_data.y_second - in_data.y_first) :
                 16'(in_data.y_first - in_data.y_second);

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_cnt   <= '0;
    end else begin
      case (state)
        S_INIT, S_CLEAR: begin
          if (clr_cnt == AW'(STORE_BYTES - 1)) begin
            clr_cnt <= '0;
            state   <= (state == S_INIT) ? S_IDLE : S_OUT;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_func <= in_data.func;
            res_data <= 8'd0;
            cx       <= in_data.x_first;
            cy       <= in_data.y_first;
            xc       <= in_data.x_first;
            yc       <= in_data.y_first;
            xb       <= in_data.x_second;
            yb       <= in_data.y_second;
            sx       <= in_data.x_first < in_data.x_second;
            sy       <= in_data.y_first < in_data.y_second;
            dx       <= 13'(in_dx);
            dy       <= -13'(in_dy);
            k        <= 2'd0;
            rd_hit   <= 16'(in_data.read_index) < 16'(STORE_BYTES);
            case (in_data.func)
              FUNC_CLEAR: state <= S_CLEAR;
              FUNC_PIXEL: begin
                shape  <= SHAPE_PIXEL;
                pix_on <= in_data.pixel_on;
                state  <= S_PLOT_RD;
              end
              FUNC_LINE: begin
                shape  <= SHAPE_LINE;
                pix_on <= 1'b1;
                err    <= 13'(in_dx) - 13'(in_dy);
                state  <= S_PLOT_RD;
              end
              FUNC_CIRCLE: begin
                shape  <= SHAPE_CIRCLE;
                pix_on <= 1'b1;
                ccx    <= -13'(in_data.radius);
                ccy    <= 13'sd0;
                err    <= 13'sd2 - (13'(in_data.radius) <<< 1);
                state  <= S_PLOT_RD;
              end
              FUNC_READ: state <= S_READ;
              default:   state <= S_OUT;
            endcase
          end
        end
        S_PLOT_RD: begin
          wr_addr <= pt_idx[AW-1:0];
          wr_bit  <= pt_y[2:0];
          wr_hit  <= pt_idx < 16'(STORE_BYTES);
          state   <= S_PLOT_WR;
        end
        S_PLOT_WR: begin
          case (shape)
            SHAPE_LINE: state <= S_LSTEP;
            SHAPE_CIRCLE: begin
              k     <= k + 2'd1;
              state <= (k == 2'd3) ? S_CSTEP : S_PLOT_RD;
            end
            default: state <= S_OUT;
          endcase
        end
        S_LSTEP: begin
          err   <= l_err;
          cx    <= l_cx;
          cy    <= l_cy;
          state <= l_done ? S_OUT : S_PLOT_RD;
        end
        S_CSTEP: begin
          err   <= c_err;
          ccx   <= c_x;
          ccy   <= c_y;
          state <= (c_x > 13'sd0) ? S_OUT : S_PLOT_RD;
        end
        S_READ: begin
          res_data <= rd_hit ? ram_rdata : 8'd0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  a_reset_init: assert property (@(posedge clk) rst |=> state == S_INIT)
    else $error("engine did not restart the clearing pass");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while busy");
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_INIT || state == S_CLEAR || state == S_PLOT_WR))
    else $error("store written outside a write step");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("pending result changed");
endmodule

### rtl/core/mfb_ram.sv
`timescale 1ns / 1ps
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
